// ===== hdl/assert_macros.svh =====
// Assertion shorthands shared by the transcoder modules.
// Each module that uses them names its clock clk and its reset arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define U2A_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define U2A_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/u2a_pkg.sv =====
// ----------------------------------------------------------------------------
// u2a_pkg
// Types and constants of the UTF-8 / ASCII transcoder: register map, report
// status codes, decoder limits and the work entry passed from front to back.
// ----------------------------------------------------------------------------
package u2a_pkg;

	typedef enum logic [1:0] {
		REG_SOURCE_CHARSET  = 2'd0,
		REG_TARGET_CHARSET  = 2'd1,
		REG_TRANSLIT_ENABLE = 2'd2,
		REG_IGNORE_ENABLE   = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_ILLEGAL    = 2'd1,
		STATUS_INCOMPLETE = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		KIND_DATA   = 1'b0,
		KIND_REPORT = 1'b1
	} kind_t;

	localparam logic [20:0] CODE_MAX    = 21'h10FFFF;
	localparam logic [20:0] QMARK_CODE  = 21'h00003F;
	localparam logic [7:0]  LEAD_2_MIN  = 8'hC2;
	localparam logic [7:0]  LEAD_2_MAX  = 8'hDF;
	localparam logic [7:0]  LEAD_3_MIN  = 8'hE0;
	localparam logic [7:0]  LEAD_3_MAX  = 8'hEF;
	localparam logic [7:0]  LEAD_4_MIN  = 8'hF0;
	localparam logic [7:0]  LEAD_4_MAX  = 8'hF4;
	localparam logic [7:0]  LEAD_SURR   = 8'hED;
	localparam logic [7:0]  CONT_E0_MIN = 8'hA0;
	localparam logic [7:0]  CONT_F0_MIN = 8'h90;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic         src_ascii;
		logic         tgt_ascii;
		logic         translit;
		logic         ignore;
	} cfg_t;

	// One decoded step: at most one character to encode and an optional report.
	typedef struct packed {
		logic         has_char;
		logic [20:0]  code;
		logic         has_report;
		status_t      status;
		logic [31:0]  count;
	} entry_t;

endpackage

// ===== hdl/u2a_front.sv =====
// ----------------------------------------------------------------------------
// u2a_front
// Strict UTF-8 / ASCII decoder. Takes one byte per cycle while not stalled,
// keeps the pending sequence and lossy count, and queues one entry per step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u2a_front #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  u2a_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              q_full,
	output logic              push,
	output u2a_pkg::entry_t   push_entry
);

	logic [7:0]             lead_q, lead_d;
	logic [20:0]            part_q, part_d;
	logic [1:0]             rem_q, rem_d;
	logic [1:0]             seen_q, seen_d;
	logic                   halt_q, halt_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_sat;
	logic [COUNT_WIDTH:0]   cnt_sum;

	logic        accept;
	logic        cont_ok;
	logic        taken;
	logic        stop;
	logic        bump_a;
	logic        bump_b;
	logic        want_emit;
	logic [20:0] cand;
	logic [20:0] shifted;
	logic        has_char;
	logic [20:0] code;
	logic        has_report;
	u2a_pkg::status_t rep_status;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;
	assign shifted  = {part_q[14:0], in_byte[5:0]};

	always_comb begin
		cont_ok = (in_byte[7:6] == 2'b10);
		if (seen_q == 2'd0) begin
			if ((lead_q == u2a_pkg::LEAD_3_MIN && in_byte <  u2a_pkg::CONT_E0_MIN) ||
			    (lead_q == u2a_pkg::LEAD_SURR  && in_byte >= u2a_pkg::CONT_E0_MIN) ||
			    (lead_q == u2a_pkg::LEAD_4_MIN && in_byte <  u2a_pkg::CONT_F0_MIN) ||
			    (lead_q == u2a_pkg::LEAD_4_MAX && in_byte >= u2a_pkg::CONT_F0_MIN)) begin
				cont_ok = 1'b0;
			end
		end
	end

	always_comb begin
		lead_d     = lead_q;
		part_d     = part_q;
		rem_d      = rem_q;
		seen_d     = seen_q;
		halt_d     = halt_q;
		stop       = 1'b0;
		bump_a     = 1'b0;
		bump_b     = 1'b0;
		taken      = 1'b0;
		want_emit  = 1'b0;
		cand       = '0;
		has_char   = 1'b0;
		code       = '0;
		has_report = 1'b0;
		rep_status = u2a_pkg::STATUS_OK;

		// Continuation of a pending sequence
		if (rem_q != 2'd0) begin
			if (!cont_ok) begin
				rem_d  = 2'd0;
				seen_d = 2'd0;
				part_d = '0;
				if (cfg.ignore) begin
					bump_a = 1'b1;
				end else begin
					stop = 1'b1;
				end
			end else begin
				part_d = shifted;
				seen_d = 2'(seen_q + 2'd1);
				rem_d  = 2'(rem_q - 2'd1);
				taken  = 1'b1;
				if (rem_q == 2'd1) begin
					seen_d = 2'd0;
					part_d = '0;
					if (shifted > u2a_pkg::CODE_MAX) begin
						if (cfg.ignore) begin
							bump_a = 1'b1;
						end else begin
							stop = 1'b1;
						end
					end else begin
						want_emit = 1'b1;
						cand      = shifted;
					end
				end
			end
		end

		// Lead byte, including a byte that broke the pending sequence
		if (!taken && !stop) begin
			if (!in_byte[7]) begin
				want_emit = 1'b1;
				cand      = {13'd0, in_byte};
			end else if (!cfg.src_ascii && in_byte >= u2a_pkg::LEAD_2_MIN &&
			             in_byte <= u2a_pkg::LEAD_2_MAX) begin
				rem_d  = 2'd1;
				part_d = {16'd0, in_byte[4:0]};
				lead_d = in_byte;
				seen_d = 2'd0;
			end else if (!cfg.src_ascii && in_byte >= u2a_pkg::LEAD_3_MIN &&
			             in_byte <= u2a_pkg::LEAD_3_MAX) begin
				rem_d  = 2'd2;
				part_d = {17'd0, in_byte[3:0]};
				lead_d = in_byte;
				seen_d = 2'd0;
			end else if (!cfg.src_ascii && in_byte >= u2a_pkg::LEAD_4_MIN &&
			             in_byte <= u2a_pkg::LEAD_4_MAX) begin
				rem_d  = 2'd3;
				part_d = {18'd0, in_byte[2:0]};
				lead_d = in_byte;
				seen_d = 2'd0;
			end else if (cfg.ignore) begin
				bump_b = 1'b1;
			end else begin
				stop = 1'b1;
			end
		end

		// Target side: replace, drop or stop on characters ASCII cannot hold
		if (want_emit) begin
			if (cfg.tgt_ascii && cand[20:7] != 14'd0) begin
				if (cfg.translit) begin
					has_char = 1'b1;
					code     = u2a_pkg::QMARK_CODE;
					bump_b   = 1'b1;
				end else if (cfg.ignore) begin
					bump_b = 1'b1;
				end else begin
					stop = 1'b1;
				end
			end else begin
				has_char = 1'b1;
				code     = cand;
			end
		end

		cnt_sum = {1'b0, cnt_q} + (COUNT_WIDTH+1)'(bump_a) + (COUNT_WIDTH+1)'(bump_b);
		cnt_sat = cnt_sum[COUNT_WIDTH] ? '1 : cnt_sum[COUNT_WIDTH-1:0];
		cnt_d   = cnt_sat;

		if (stop) begin
			has_report = 1'b1;
			rep_status = u2a_pkg::STATUS_ILLEGAL;
			if (!in_last) begin
				halt_d = 1'b1;
			end
		end else if (in_last) begin
			has_report = 1'b1;
			rep_status = (rem_d != 2'd0) ? u2a_pkg::STATUS_INCOMPLETE : u2a_pkg::STATUS_OK;
		end

		// Halted: drop everything until the last byte rearms the stream
		if (halt_q) begin
			lead_d     = lead_q;
			part_d     = part_q;
			rem_d      = rem_q;
			seen_d     = seen_q;
			halt_d     = halt_q;
			cnt_d      = cnt_q;
			has_char   = 1'b0;
			has_report = 1'b0;
		end

		if (in_last && (halt_q || !stop || stop)) begin
			lead_d = '0;
			part_d = '0;
			rem_d  = 2'd0;
			seen_d = 2'd0;
			halt_d = 1'b0;
			cnt_d  = '0;
		end
	end

	assign push                  = accept && (has_char || has_report);
	assign push_entry.has_char   = has_char;
	assign push_entry.code       = code;
	assign push_entry.has_report = has_report;
	assign push_entry.status     = rep_status;
	assign push_entry.count      = 32'(cnt_sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
			part_q <= '0;
			rem_q  <= 2'd0;
			seen_q <= 2'd0;
			halt_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			lead_q <= lead_d;
			part_q <= part_d;
			rem_q  <= rem_d;
			seen_q <= seen_d;
			halt_q <= halt_d;
			cnt_q  <= cnt_d;
		end
	end

	`U2A_ASSERT(a_halt_quiet, halt_q |-> !push, "halted front pushed an entry")
	`U2A_ASSERT(a_seen_idle, (rem_q == 2'd0) |-> (seen_q == 2'd0), "seen count with no sequence")

endmodule

// ===== hdl/u2a_queue.sv =====
// ----------------------------------------------------------------------------
// u2a_queue
// Short entry queue between decoder and encoder, so either side can stall
// without holding the other.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u2a_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  u2a_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output u2a_pkg::entry_t head_entry
);

	u2a_pkg::entry_t                 mem_q [u2a_pkg::QUEUE_DEPTH];
	logic [u2a_pkg::QUEUE_AW-1:0]    wr_ptr_q;
	logic [u2a_pkg::QUEUE_AW-1:0]    rd_ptr_q;
	logic [u2a_pkg::QUEUE_AW:0]      cnt_q;

	assign full       = (cnt_q == (u2a_pkg::QUEUE_AW+1)'(u2a_pkg::QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= u2a_pkg::QUEUE_AW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= u2a_pkg::QUEUE_AW'(rd_ptr_q + 1'b1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= (u2a_pkg::QUEUE_AW+1)'(cnt_q + 1'b1);
				2'b01:   cnt_q <= (u2a_pkg::QUEUE_AW+1)'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`U2A_ASSERT(a_no_overflow, push |-> (!full || pop), "push into a full queue")

endmodule

// ===== hdl/u2a_back.sv =====
// ----------------------------------------------------------------------------
// u2a_back
// Encoder. Expands the head entry into its UTF-8 bytes and optional end
// report, one beat per cycle unless stalled, via a registered output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u2a_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  u2a_pkg::entry_t head_entry,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      out_byte,
	output logic            result_kind,
	output logic [1:0]      status,
	output logic [31:0]     irreversible_count,
	output logic            run_last
);

	logic [2:0]  phase_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        kind_q;
	logic [1:0]  status_q;
	logic [31:0] count_q;
	logic        last_q;

	logic        load;
	logic [2:0]  nbytes;
	logic [2:0]  total;
	logic        final_beat;
	logic [1:0]  rpos;
	logic [7:0]  data_byte;
	logic [20:0] code;

	assign code = head_entry.code;

	always_comb begin
		if (!head_entry.has_char) begin
			nbytes = 3'd0;
		end else if (code[20:7] == 14'd0) begin
			nbytes = 3'd1;
		end else if (code[20:11] == 10'd0) begin
			nbytes = 3'd2;
		end else if (code[20:16] == 5'd0) begin
			nbytes = 3'd3;
		end else begin
			nbytes = 3'd4;
		end
	end

	assign total      = 3'(nbytes + {2'd0, head_entry.has_report});
	assign final_beat = (phase_q == 3'(total - 3'd1));
	assign rpos       = 2'(nbytes - 3'd1 - phase_q);

	always_comb begin
		if (phase_q == 3'd0) begin
			unique case (nbytes)
				3'd1:    data_byte = code[7:0];
				3'd2:    data_byte = {3'b110, code[10:6]};
				3'd3:    data_byte = {4'b1110, code[15:12]};
				default: data_byte = {5'b11110, code[20:18]};
			endcase
		end else begin
			case (rpos)
				2'd0:    data_byte = {2'b10, code[5:0]};
				2'd1:    data_byte = {2'b10, code[11:6]};
				default: data_byte = {2'b10, code[17:12]};
			endcase
		end
	end

	assign load = head_valid && (!out_valid_q || !out_stall);
	assign pop  = load && final_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q     <= final_beat ? 3'd0 : 3'(phase_q + 3'd1);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= final_beat;
			if (phase_q < nbytes) begin
				byte_q   <= data_byte;
				kind_q   <= u2a_pkg::KIND_DATA;
				status_q <= u2a_pkg::STATUS_OK;
				count_q  <= '0;
			end else begin
				byte_q   <= '0;
				kind_q   <= u2a_pkg::KIND_REPORT;
				status_q <= head_entry.status;
				count_q  <= head_entry.count;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign out_byte           = byte_q;
	assign result_kind        = kind_q;
	assign status             = status_q;
	assign irreversible_count = count_q;
	assign run_last           = last_q;

	`U2A_ASSERT_NEXT(a_phase_restart, pop, phase_q == 3'd0, "phase not reset after pop")
	`U2A_ASSERT(a_phase_range, phase_q <= 3'd4, "phase beyond five beats")

endmodule

// ===== hdl/utf8_ascii_transcoder_unit.sv =====
// Path: a taken byte is written into the queue, then loaded into the
// encoder's output register, where its first result beat can be taken.
// Throughput: one byte in per cycle unless the queue is full, one result beat
// out per cycle unless out_stall is set. Each result of a byte (up to four
// data bytes and a report) takes one beat; a four-entry queue absorbs bursts.
// Reset: arst_n at once clears config, decoder, count and queue pointers.
// ----------------------------------------------------------------------------
// utf8_ascii_transcoder_unit
// Byte-stream transcoder between UTF-8 and ASCII with strict decoding,
// replace or skip of lossy characters, and an end-of-stream report.
// ----------------------------------------------------------------------------
module utf8_ascii_transcoder_unit #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        result_kind,
	output logic [1:0]  status,
	output logic [31:0] irreversible_count,
	output logic        run_last
);

	u2a_pkg::cfg_t       cfg_q;
	u2a_pkg::reg_index_t reg_idx;
	logic                cfg_wr;

	logic            q_full;
	logic            push;
	u2a_pkg::entry_t push_entry;
	logic            pop;
	logic            head_valid;
	u2a_pkg::entry_t head_entry;

	assign pready  = 1'b1;
	assign reg_idx = u2a_pkg::reg_index_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				u2a_pkg::REG_SOURCE_CHARSET:  cfg_q.src_ascii <= pwdata[0];
				u2a_pkg::REG_TARGET_CHARSET:  cfg_q.tgt_ascii <= pwdata[0];
				u2a_pkg::REG_TRANSLIT_ENABLE: cfg_q.translit  <= pwdata[0];
				u2a_pkg::REG_IGNORE_ENABLE:   cfg_q.ignore    <= pwdata[0];
				default:                      cfg_q           <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			u2a_pkg::REG_SOURCE_CHARSET:  prdata = {31'd0, cfg_q.src_ascii};
			u2a_pkg::REG_TARGET_CHARSET:  prdata = {31'd0, cfg_q.tgt_ascii};
			u2a_pkg::REG_TRANSLIT_ENABLE: prdata = {31'd0, cfg_q.translit};
			u2a_pkg::REG_IGNORE_ENABLE:   prdata = {31'd0, cfg_q.ignore};
			default:                      prdata = '0;
		endcase
	end

	u2a_front #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	u2a_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	u2a_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.head_valid         (head_valid),
		.head_entry         (head_entry),
		.pop                (pop),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.out_byte           (out_byte),
		.result_kind        (result_kind),
		.status             (status),
		.irreversible_count (irreversible_count),
		.run_last           (run_last)
	);

endmodule

// ===== tb/tb_utf8_ascii_transcoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_ascii_transcoder_unit
// Drives byte streams through the transcoder under a range of register
// settings and checks every result beat against a cycle-free model of the
// strict decoder, the encoder and the end-of-stream report.
// ----------------------------------------------------------------------------
module tb_utf8_ascii_transcoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		logic [7:0]        data;
		u2a_pkg::kind_t    kind;
		u2a_pkg::status_t  status;
		logic [31:0]       count;
		logic              run_last;
	} beat_t;

	class transcode_scoreboard;
		u2a_pkg::cfg_t cfg;
		logic [7:0]  lead;
		logic [20:0] partial;
		logic [1:0]  remaining;
		logic [1:0]  seen;
		bit          halted;
		bit          stopped;
		logic [31:0] lossy;
		beat_t       step_beats[$];
		beat_t       pending_beats[$];
		int          errors;

		function new();
			cfg = '0;
			errors = 0;
			clear_stream();
		endfunction

		static function byte_q_t utf8_encode(logic [20:0] c);
			byte_q_t q;
			if (c < 21'h80) begin
				q.push_back(c[7:0]);
			end else if (c < 21'h800) begin
				q.push_back({3'b110, c[10:6]});
				q.push_back({2'b10, c[5:0]});
			end else if (c < 21'h10000) begin
				q.push_back({4'b1110, c[15:12]});
				q.push_back({2'b10, c[11:6]});
				q.push_back({2'b10, c[5:0]});
			end else begin
				q.push_back({5'b11110, c[20:18]});
				q.push_back({2'b10, c[17:12]});
				q.push_back({2'b10, c[11:6]});
				q.push_back({2'b10, c[5:0]});
			end
			return q;
		endfunction

		function void set_register(u2a_pkg::reg_index_t idx, logic v);
			case (idx)
				u2a_pkg::REG_SOURCE_CHARSET:  cfg.src_ascii = v;
				u2a_pkg::REG_TARGET_CHARSET:  cfg.tgt_ascii = v;
				u2a_pkg::REG_TRANSLIT_ENABLE: cfg.translit = v;
				u2a_pkg::REG_IGNORE_ENABLE:   cfg.ignore = v;
				default: ;
			endcase
		endfunction

		function void clear_stream();
			lead = '0;
			partial = '0;
			remaining = '0;
			seen = '0;
			halted = 0;
			lossy = '0;
		endfunction

		function void bump_count();
			if (lossy != '1)
				lossy = lossy + 1;
		endfunction

		function void add_beat(logic [7:0] b, u2a_pkg::kind_t k, u2a_pkg::status_t s);
			beat_t r;
			r.data = b;
			r.kind = k;
			r.status = s;
			r.count = (k == u2a_pkg::KIND_REPORT) ? lossy : '0;
			r.run_last = 0;
			step_beats.push_back(r);
		endfunction

		function void reject_input();
			if (cfg.ignore)
				bump_count();
			else
				stopped = 1;
		endfunction

		function void encode_char(logic [20:0] c);
			byte_q_t q;
			if (cfg.tgt_ascii && c >= 21'h80) begin
				if (cfg.translit) begin
					add_beat(u2a_pkg::QMARK_CODE[7:0], u2a_pkg::KIND_DATA,
						u2a_pkg::STATUS_OK);
					bump_count();
				end else begin
					reject_input();
				end
			end else begin
				q = utf8_encode(c);
				foreach (q[i])
					add_beat(q[i], u2a_pkg::KIND_DATA, u2a_pkg::STATUS_OK);
			end
		endfunction

		function void start_char(logic [7:0] b);
			if (!b[7]) begin
				encode_char({13'b0, b});
			end else if (cfg.src_ascii) begin
				reject_input();
			end else if (b >= u2a_pkg::LEAD_2_MIN && b <= u2a_pkg::LEAD_2_MAX) begin
				remaining = 2'd1;
				partial = {16'b0, b[4:0]};
			end else if (b >= u2a_pkg::LEAD_3_MIN && b <= u2a_pkg::LEAD_3_MAX) begin
				remaining = 2'd2;
				partial = {17'b0, b[3:0]};
			end else if (b >= u2a_pkg::LEAD_4_MIN && b <= u2a_pkg::LEAD_4_MAX) begin
				remaining = 2'd3;
				partial = {18'b0, b[2:0]};
			end else begin
				reject_input();
			end
			if (remaining != 0 && b[7] && !cfg.src_ascii) begin
				lead = b;
				seen = '0;
			end
		endfunction

		// Work out the beats that one accepted byte causes and queue them.
		function void transcode_byte(logic [7:0] b, logic last);
			bit          bad;
			bit          taken;
			logic [20:0] c;
			step_beats.delete();
			stopped = 0;
			taken = 0;
			if (halted) begin
				if (last)
					clear_stream();
				return;
			end
			if (remaining != 0) begin
				bad = b[7:6] != 2'b10;
				// the first continuation byte also guards against overlong,
				// surrogate and out-of-range forms
				if (!bad && seen == 0)
					bad = (lead == u2a_pkg::LEAD_3_MIN && b < u2a_pkg::CONT_E0_MIN) ||
					      (lead == u2a_pkg::LEAD_SURR && b >= u2a_pkg::CONT_E0_MIN) ||
					      (lead == u2a_pkg::LEAD_4_MIN && b < u2a_pkg::CONT_F0_MIN) ||
					      (lead == u2a_pkg::LEAD_4_MAX && b >= u2a_pkg::CONT_F0_MIN);
				if (bad) begin
					remaining = '0;
					seen = '0;
					partial = '0;
					reject_input();
				end else begin
					partial = {partial[14:0], b[5:0]};
					seen = seen + 2'd1;
					remaining = remaining - 2'd1;
					taken = 1;
					if (remaining == 0) begin
						c = partial;
						seen = '0;
						partial = '0;
						if (c > u2a_pkg::CODE_MAX)
							reject_input();
						else
							encode_char(c);
					end
				end
			end
			if (!taken && !stopped)
				start_char(b);
			if (stopped) begin
				add_beat('0, u2a_pkg::KIND_REPORT, u2a_pkg::STATUS_ILLEGAL);
				if (last)
					clear_stream();
				else
					halted = 1;
			end else if (last) begin
				add_beat('0, u2a_pkg::KIND_REPORT,
					remaining != 0 ? u2a_pkg::STATUS_INCOMPLETE : u2a_pkg::STATUS_OK);
				clear_stream();
			end
			if (step_beats.size() > 0)
				step_beats[step_beats.size() - 1].run_last = 1;
			foreach (step_beats[i])
				pending_beats.push_back(step_beats[i]);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		function void compare_beat(beat_t got);
			beat_t want;
			if (pending_beats.size() == 0) begin
				flag($sformatf("unexpected beat: byte %02h kind %0d status %0d count %0d last %0d",
					got.data, got.kind, got.status, got.count, got.run_last));
				return;
			end
			want = pending_beats.pop_front();
			if (want.data !== got.data || want.kind !== got.kind ||
			    want.status !== got.status || want.count !== got.count ||
			    want.run_last !== got.run_last)
				flag($sformatf({"mismatch: expected byte %02h kind %0d status %0d count %0d ",
					"last %0d, got byte %02h kind %0d status %0d count %0d last %0d"},
					want.data, want.kind, want.status, want.count, want.run_last,
					got.data, got.kind, got.status, got.count, got.run_last));
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 0;
	logic        in_stall;
	logic [7:0]  in_byte = '0;
	logic        in_last = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [7:0]  out_byte;
	logic        result_kind;
	logic [1:0]  status;
	logic [31:0] irreversible_count;
	logic        run_last;

	int send_idle = 0;
	int recv_idle = 0;
	int hold_req = 0;

	transcode_scoreboard scb;

	utf8_ascii_transcoder_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
		.out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
		.result_kind(result_kind), .status(status),
		.irreversible_count(irreversible_count), .run_last(run_last)
	);

	always #5 clk = ~clk;

	initial begin
		#3ms;
		$display("Verification failed");
		$finish;
	end

	task automatic write_register(u2a_pkg::reg_index_t idx, logic v);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= {31'b0, v};
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		scb.set_register(idx, v);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
	endtask

	task automatic configure(u2a_pkg::cfg_t c);
		write_register(u2a_pkg::REG_SOURCE_CHARSET, c.src_ascii);
		write_register(u2a_pkg::REG_TARGET_CHARSET, c.tgt_ascii);
		write_register(u2a_pkg::REG_TRANSLIT_ENABLE, c.translit);
		write_register(u2a_pkg::REG_IGNORE_ENABLE, c.ignore);
	endtask

	task automatic send_byte(logic [7:0] b, logic last);
		int gap;
		gap = $urandom_range(0, send_idle);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		in_byte <= b;
		in_last <= last;
		do @(posedge clk); while (in_stall);
		scb.transcode_byte(b, last);
	endtask

	task automatic send_bytes(byte_q_t seq, logic close);
		foreach (seq[i])
			send_byte(seq[i], close && i == seq.size() - 1);
	endtask

	// Drop valid and hold until every expected beat is back.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 0;
		while (scb.pending_beats.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic receive_loop();
		int    n;
		beat_t got;
		forever begin
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
			end else begin
				n = $urandom_range(0, recv_idle);
			end
			@(negedge clk);
			if (n > 0) begin
				out_stall <= 1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!out_valid);
			got.data = out_byte;
			got.kind = u2a_pkg::kind_t'(result_kind);
			got.status = u2a_pkg::status_t'(status);
			got.count = irreversible_count;
			got.run_last = run_last;
			scb.compare_beat(got);
		end
	endtask

	// Mostly well-formed characters, with some noise and cut-off sequences.
	task automatic random_stream(int n_items);
		int          sent;
		int          pick;
		logic [20:0] c;
		byte_q_t     seq;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			seq.delete();
			if (pick < 40) begin
				seq.push_back(8'($urandom_range(0, 127)));
			end else if (pick < 55) begin
				seq = transcode_scoreboard::utf8_encode(21'($urandom_range('h80, 'h7FF)));
			end else if (pick < 70) begin
				c = 21'($urandom_range('h800, 'hFFFF));
				if (c[15:11] == 5'b11011)
					c[12] = ~c[12];
				seq = transcode_scoreboard::utf8_encode(c);
			end else if (pick < 80) begin
				seq = transcode_scoreboard::utf8_encode(21'($urandom_range('h10000, 'h10FFFF)));
			end else if (pick < 90) begin
				seq.push_back(8'($urandom_range(0, 255)));
			end else begin
				seq = transcode_scoreboard::utf8_encode(21'($urandom_range('h800, 'h10FFFF)));
				void'(seq.pop_back());
				if (pick[0])
					void'(seq.pop_back());
			end
			foreach (seq[i]) begin
				send_byte(seq[i], $urandom_range(0, 24) == 0);
				sent++;
			end
		end
	endtask

	initial begin
		u2a_pkg::cfg_t c;
		scb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		fork
			receive_loop();
		join_none

		// one- and two-byte extremes, top three- and four-byte forms, strict mode
		c = '0;
		configure(c);
		send_bytes('{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF}, 0);
		send_bytes('{8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1);
		drain_results();

		// breaking bytes, overlong, surrogate and out-of-range forms, skipped
		c.ignore = 1;
		configure(c);
		send_bytes('{8'hC3, 8'h41, 8'hE0, 8'h80, 8'hED, 8'hA0, 8'hF4, 8'h90}, 1);
		drain_results();

		// stop mid-stream, rearm on the last byte, then a stop on the last byte
		c = '0;
		configure(c);
		send_bytes('{8'hC0, 8'h41}, 1);
		send_bytes('{8'hFF}, 1);
		drain_results();

		// ASCII target with translit and ignore both set; leave a sequence open
		c.tgt_ascii = 1;
		c.translit = 1;
		c.ignore = 1;
		configure(c);
		send_bytes('{8'hC3, 8'hA9, 8'hE2, 8'h82}, 0);
		drain_results();

		// change of source charset with a sequence still pending
		c.src_ascii = 1;
		c.ignore = 0;
		configure(c);
		send_bytes('{8'hAC}, 1);
		drain_results();

		for (int p = 0; p < 8; p++) begin
			if (p == 0)
				c = '0;
			else if (p == 7)
				c = '1;
			else
				c = u2a_pkg::cfg_t'(4'($urandom_range(0, 15)));
			configure(c);
			send_idle = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 9 : 3;
			recv_idle = (p % 3 == 1) ? 0 : (p % 3 == 2) ? 9 : 3;
			// long receiver hold while bytes keep coming
			if (p == 2)
				hold_req = 100;
			random_stream(55);
			drain_results();
		end

		repeat (20) @(posedge clk);
		if (scb.errors == 0 && scb.pending_beats.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
